// ----- hw/rtl/cielab_to_srgb_converter_top_macros.svh -----
// ----------------------------------------------------------------------------
// CIELAB to sRGB converter - assertion macros
// Concurrent assertion helpers clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIELAB_TO_SRGB_CONVERTER_TOP_MACROS_SVH
`define CIELAB_TO_SRGB_CONVERTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define C2S_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c2srgb same-cycle check failed");
// Next-cycle implication.
`define C2S_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c2srgb next-cycle check failed");
`else
`define C2S_ASSERT_IMP(lbl, ante, cons)
`define C2S_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/c2srgb_pkg.sv -----
// ----------------------------------------------------------------------------
// c2srgb_pkg
// Shared Q3.16 types, conversion constants and rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package c2srgb_pkg;

  localparam int Q_W = 20;
  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    q_t c0;
    q_t c1;
    q_t c2;
  } q3_t;

  localparam q_t Q_MAX = 20'sd524287;
  localparam q_t Q_MIN = -20'sd524288;

  // Inverse Lab function
  localparam q_t LAB_KNEE = 20'sd13559;
  localparam q_t LAB_OFF = 20'sd9039;
  localparam q_t CUBE_SAT = 20'sd131072;
  localparam logic signed [15:0] LAB_SLOPE = 16'sd8416;

  // D65 white point (X and Z, Y is one)
  localparam logic signed [17:0] WHITE_X = 18'sd62290;
  localparam logic signed [17:0] WHITE_Z = 18'sd71358;

  typedef logic signed [18:0] coef_t;
  localparam coef_t RGB_COEF [3][3] = '{
    '{19'sd212366, -19'sd100738, -19'sd32672},
    '{-19'sd63522, 19'sd122946, 19'sd2723},
    '{19'sd3647, -19'sd13371, 19'sd69286}
  };

  // Gamma encoder
  localparam int G_W = 18;
  typedef logic signed [G_W-1:0] g_t;
  localparam q_t GAM_LIN_MAX = 20'sd205;
  localparam q_t GAM_ONE = 20'sd65536;
  localparam logic [15:0] GAM_LIN_MUL = 16'd32946;

  typedef enum logic [1:0] {
    GC_LIN,
    GC_TAB,
    GC_SAT
  } gcls_t;

  // Round half away from zero, divide by 2^16.
  function automatic logic signed [47:0] rsh16(input logic signed [47:0] n);
    logic signed [47:0] m;
    if (n >= 0) begin
      m = (n + 48'sd32768) >>> 16;
    end else begin
      m = -((-n + 48'sd32768) >>> 16);
    end
    return m;
  endfunction

  function automatic q_t sat_q(input logic signed [47:0] v);
    q_t r;
    if (v > 48'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < 48'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = q_t'(v);
    end
    return r;
  endfunction

  function automatic logic [63:0] mul30(input logic [63:0] x, input logic [63:0] y);
    return (x * y + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] pow30(input logic [63:0] x, input int n);
    logic [63:0] r;
    r = 64'd1 << 30;
    for (int k = 0; k < n; k++) begin
      r = mul30(r, x);
    end
    return r;
  endfunction

  // 1.055 * x^(1/2.4) - 0.055 in Q16 for x in Q30, root by bisection.
  function automatic g_t gamma_point(input logic [63:0] x);
    logic [63:0] x5;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    x5 = pow30(x, 5);
    lo = 64'd0;
    hi = 64'd65536;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (pow30(mid << 14, 12) <= x5) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return g_t'(((64'd69140 * lo + 64'd32768) >> 16) - 64'd3604);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/c2srgb_front.sv -----
// ----------------------------------------------------------------------------
// c2srgb_front
// Two-stage front end: forms fy, fx and fz from the Lab inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module c2srgb_front #(
  parameter int INPUT_FRAC_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [14:0]             l_value,
  input  wire logic signed [15:0]      a_value,
  input  wire logic signed [15:0]      b_value,
  output c2srgb_pkg::q3_t              f_o
);

  localparam int SH = 16 - INPUT_FRAC_BITS;
  localparam int LQ_W = 15 + SH;
  localparam int FY_W = ((LQ_W > 21) ? LQ_W : 21) + 1;
  localparam int FY_S = FY_W + 7;
  localparam int FY_MW = FY_S - 6;
  localparam int FYP_W = FY_W + FY_MW;
  localparam logic [FY_MW-1:0] FY_M = FY_MW'(((64'd1 << FY_S) + 64'd115) / 64'd116);
  localparam int FY_BIAS = 16 * 65536 + 58;

  localparam int A_W = 16 + SH;
  localparam int A_S = A_W + 9;
  localparam int A_MW = A_S - 8;
  localparam int AP_W = A_W + A_MW;
  localparam logic [A_MW-1:0] A_M = A_MW'(((64'd1 << A_S) + 64'd499) / 64'd500);

  localparam int B_S = A_W + 8;
  localparam int B_MW = B_S - 7;
  localparam int BP_W = A_W + B_MW;
  localparam logic [B_MW-1:0] B_M = B_MW'(((64'd1 << B_S) + 64'd199) / 64'd200);

  logic [FY_W-1:0]  fy_num;
  logic [15:0]      a_mag;
  logic [15:0]      b_mag;
  logic [A_W-1:0]   a_num;
  logic [A_W-1:0]   b_num;
  logic [FYP_W-1:0] fy_prod_nxt, fy_prod_r;
  logic [AP_W-1:0]  a_prod_nxt, a_prod_r;
  logic [BP_W-1:0]  b_prod_nxt, b_prod_r;
  logic             a_neg_r, b_neg_r;
  logic signed [47:0] fy48, qa48, qb48;
  c2srgb_pkg::q_t   fy;
  c2srgb_pkg::q3_t  f_nxt, f_r;

  // Stage 1: magnitudes plus half divisor, times reciprocal
  always_comb begin
    fy_num = (FY_W'(l_value) << SH) + FY_W'(FY_BIAS);
    a_mag = a_value[15] ? 16'(-a_value) : 16'(a_value);
    b_mag = b_value[15] ? 16'(-b_value) : 16'(b_value);
    a_num = (A_W'(a_mag) << SH) + A_W'(250);
    b_num = (A_W'(b_mag) << SH) + A_W'(100);
    fy_prod_nxt = FYP_W'(fy_num) * FYP_W'(FY_M);
    a_prod_nxt = AP_W'(a_num) * AP_W'(A_M);
    b_prod_nxt = BP_W'(b_num) * BP_W'(B_M);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fy_prod_r <= fy_prod_nxt;
      a_prod_r <= a_prod_nxt;
      b_prod_r <= b_prod_nxt;
      a_neg_r <= a_value[15];
      b_neg_r <= b_value[15];
    end
  end

  // Stage 2: quotients, restore signs, combine and saturate
  always_comb begin
    fy48 = signed'(48'(fy_prod_r >> FY_S));
    qa48 = signed'(48'(a_prod_r >> A_S));
    qb48 = signed'(48'(b_prod_r >> B_S));
    if (a_neg_r) begin
      qa48 = -qa48;
    end
    if (b_neg_r) begin
      qb48 = -qb48;
    end
    fy = c2srgb_pkg::sat_q(fy48);
    f_nxt.c0 = c2srgb_pkg::sat_q(48'(fy) + qa48);
    f_nxt.c1 = fy;
    f_nxt.c2 = c2srgb_pkg::sat_q(48'(fy) - qb48);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= f_nxt;
    end
  end

  assign f_o = f_r;

endmodule

`default_nettype wire

// ----- hw/rtl/c2srgb_labinv.sv -----
// ----------------------------------------------------------------------------
// c2srgb_labinv
// Two-stage inverse Lab function: cube above the knee, line below it.
// ----------------------------------------------------------------------------
`default_nettype none

module c2srgb_labinv (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire c2srgb_pkg::q_t t_i,
  output c2srgb_pkg::q_t      r_o
);

  logic               big_r, cube_r;
  logic [16:0]        ta_nxt, ta_r;
  logic [33:0]        sq_nxt, sq_r;
  logic signed [20:0] dm;
  logic signed [34:0] lin_nxt, lin_r;
  logic [50:0]        cube_full;
  logic [18:0]        cube_v;
  c2srgb_pkg::q_t     r_nxt, r_r;

  always_comb begin
    ta_nxt = t_i[16:0];
    sq_nxt = 34'(ta_nxt) * 34'(ta_nxt);
    dm = 21'(t_i) - 21'(c2srgb_pkg::LAB_OFF);
    lin_nxt = 35'(dm) * 35'(c2srgb_pkg::LAB_SLOPE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big_r <= (t_i >= c2srgb_pkg::CUBE_SAT);
      cube_r <= (t_i > c2srgb_pkg::LAB_KNEE);
      ta_r <= ta_nxt;
      sq_r <= sq_nxt;
      lin_r <= lin_nxt;
    end
  end

  always_comb begin
    cube_full = 51'(sq_r) * 51'(ta_r);
    cube_v = 19'((cube_full + 51'(64'd1 << 31)) >> 32);
    if (big_r) begin
      r_nxt = c2srgb_pkg::Q_MAX;
    end else if (cube_r) begin
      r_nxt = c2srgb_pkg::q_t'({1'b0, cube_v});
    end else begin
      r_nxt = c2srgb_pkg::sat_q(c2srgb_pkg::rsh16(48'(lin_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
    end
  end

  assign r_o = r_r;

endmodule

`default_nettype wire

// ----- hw/rtl/c2srgb_matrix.sv -----
// ----------------------------------------------------------------------------
// c2srgb_matrix
// Four stages: white point scaling, then the XYZ to linear RGB matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module c2srgb_matrix (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire c2srgb_pkg::q3_t lab_i,
  output c2srgb_pkg::q3_t      rgb_o
);

  logic signed [37:0] px_r, pz_r;
  c2srgb_pkg::q_t     y1_r;
  c2srgb_pkg::q_t     xyz_r [3];
  logic signed [38:0] p_r [3][3];
  logic signed [47:0] sum [3];
  c2srgb_pkg::q3_t    rgb_nxt, rgb_r;

  // White point products
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 38'(lab_i.c0) * 38'(c2srgb_pkg::WHITE_X);
      pz_r <= 38'(lab_i.c2) * 38'(c2srgb_pkg::WHITE_Z);
      y1_r <= lab_i.c1;
    end
  end

  // Round and saturate X and Z
  always_ff @(posedge clk) begin
    if (en) begin
      xyz_r[0] <= c2srgb_pkg::sat_q(c2srgb_pkg::rsh16(48'(px_r)));
      xyz_r[1] <= y1_r;
      xyz_r[2] <= c2srgb_pkg::sat_q(c2srgb_pkg::rsh16(48'(pz_r)));
    end
  end

  // Matrix products, one lane per coefficient
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_r[i][j] <= 39'(xyz_r[j]) * 39'(c2srgb_pkg::RGB_COEF[i][j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 48'(p_r[i][0]) + 48'(p_r[i][1]) + 48'(p_r[i][2]);
    end
    rgb_nxt.c0 = c2srgb_pkg::sat_q(c2srgb_pkg::rsh16(sum[0]));
    rgb_nxt.c1 = c2srgb_pkg::sat_q(c2srgb_pkg::rsh16(sum[1]));
    rgb_nxt.c2 = c2srgb_pkg::sat_q(c2srgb_pkg::rsh16(sum[2]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign rgb_o = rgb_r;

endmodule

`default_nettype wire

// ----- hw/rtl/c2srgb_gamma.sv -----
// ----------------------------------------------------------------------------
// c2srgb_gamma
// Five-stage sRGB gamma encoder with interpolated table and byte rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module c2srgb_gamma #(
  parameter int GAMMA_TABLE_ENTRIES = 1024
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire c2srgb_pkg::q_t c_i,
  output logic [7:0]          byte_o
);

  localparam int IDX_W = $clog2(GAMMA_TABLE_ENTRIES + 1);
  localparam int PW = 16 + IDX_W;

  typedef c2srgb_pkg::g_t gtab_t [0:GAMMA_TABLE_ENTRIES];

  function automatic gtab_t build_gtab();
    gtab_t tab;
    logic [63:0] x;
    for (int i = 0; i <= GAMMA_TABLE_ENTRIES; i++) begin
      x = ((64'(i) << 30) + 64'(GAMMA_TABLE_ENTRIES / 2)) / 64'(GAMMA_TABLE_ENTRIES);
      tab[i] = c2srgb_pkg::gamma_point(x);
    end
    return tab;
  endfunction

  localparam gtab_t GTAB = build_gtab();

  // Stage 1
  c2srgb_pkg::gcls_t cls1_nxt, cls1_r, cls2_r, cls3_r, cls4_r;
  logic [23:0]       lin_n;
  logic [6:0]        p_nxt, p_r;
  logic [PW-1:0]     pos;
  logic [IDX_W-1:0]  idx_r;
  logic [15:0]       frac1_r, frac2_r;

  always_comb begin
    if (c_i <= c2srgb_pkg::GAM_LIN_MAX) begin
      cls1_nxt = c2srgb_pkg::GC_LIN;
    end else if (c_i >= c2srgb_pkg::GAM_ONE) begin
      cls1_nxt = c2srgb_pkg::GC_SAT;
    end else begin
      cls1_nxt = c2srgb_pkg::GC_TAB;
    end
    lin_n = 24'(c_i[7:0]) * 24'(c2srgb_pkg::GAM_LIN_MUL);
    // Negative inputs clamp to zero on the linear segment
    p_nxt = (c_i > 0) ? 7'((lin_n + 24'd327680) >> 16) : 7'd0;
    pos = PW'(c_i[15:0]) * PW'(GAMMA_TABLE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls1_r <= cls1_nxt;
      p_r <= p_nxt;
      idx_r <= IDX_W'(pos >> 16);
      frac1_r <= pos[15:0];
    end
  end

  // Stage 2: table lookup, linear segment quotient by 10
  c2srgb_pkg::g_t g0_r, g1_r, g0b_r;
  logic [14:0]    qm;
  logic [7:0]     qlin2_r, qlin3_r, qlin4_r;

  always_comb begin
    qm = 15'(p_r) * 15'(205);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g0_r <= GTAB[idx_r];
      g1_r <= GTAB[idx_r + 1'b1];
      cls2_r <= cls1_r;
      frac2_r <= frac1_r;
      qlin2_r <= 8'(qm >> 11);
    end
  end

  // Stage 3: slope times fraction
  logic signed [18:0] dg;
  logic signed [35:0] prod_r;

  always_comb begin
    dg = 19'(g1_r) - 19'(g0_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 36'(dg) * 36'(signed'({1'b0, frac2_r}));
      g0b_r <= g0_r;
      cls3_r <= cls2_r;
      qlin3_r <= qlin2_r;
    end
  end

  // Stage 4: interpolated value
  logic signed [18:0] g_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g_r <= 19'(48'(g0b_r) + c2srgb_pkg::rsh16(48'(prod_r)));
      cls4_r <= cls3_r;
      qlin4_r <= qlin3_r;
    end
  end

  // Stage 5: scale to byte, clamp, select segment
  logic signed [27:0] gm;
  logic signed [47:0] v;
  logic [7:0]         byte_nxt, byte_r;

  always_comb begin
    gm = 28'(g_r) * 28'(9'sd255);
    v = c2srgb_pkg::rsh16(48'(gm));
    case (cls4_r)
      c2srgb_pkg::GC_LIN: byte_nxt = qlin4_r;
      c2srgb_pkg::GC_SAT: byte_nxt = 8'd255;
      c2srgb_pkg::GC_TAB: begin
        if (v < 0) begin
          byte_nxt = 8'd0;
        end else if (v > 48'sd255) begin
          byte_nxt = 8'd255;
        end else begin
          byte_nxt = v[7:0];
        end
      end
      default: byte_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_o = byte_r;

endmodule

`default_nettype wire

// ----- hw/rtl/cielab_to_srgb_converter_top.sv -----
// ----------------------------------------------------------------------------
// cielab_to_srgb_converter_top
// CIELAB (D65) to 8-bit sRGB converter, fully pipelined.
// ----------------------------------------------------------------------------
// The converter accepts one Lab transaction per clock while the output side is
// not stalled, and returns one RGB transaction per input, in order. The
// pipeline is thirteen register stages: two for the fy/fx/fz front end
// (reciprocal multiplies), two for the inverse Lab function (square, then
// cube), four for white scaling and the color matrix, and five for the gamma
// encoder (index, table read, interpolation, round, byte). All stages advance
// together whenever the output register is empty or taken, so back-pressure
// on out_ready holds every stage in place; in_ready follows it
// combinationally. The gamma curve is a constant table of
// GAMMA_TABLE_ENTRIES+1 points built at elaboration, so no fill after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cielab_to_srgb_converter_top_macros.svh"

module cielab_to_srgb_converter_top #(
  parameter int INPUT_FRAC_BITS = 8,
  parameter int GAMMA_TABLE_ENTRIES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [14:0]        in_l_value,
  input  wire logic signed [15:0] in_a_value,
  input  wire logic signed [15:0] in_b_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_red_byte,
  output logic [7:0]              out_green_byte,
  output logic [7:0]              out_blue_byte
);

  localparam int LAT = 13;

  logic            adv;
  logic [LAT-1:0]  vld_r, vld_nxt;
  c2srgb_pkg::q3_t f_vec;
  c2srgb_pkg::q3_t lin_vec;
  c2srgb_pkg::q3_t rgb_vec;

  // Advance the whole pipeline unless a finished result is waiting and out_ready is low
  assign adv = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[LAT-1];

  // Valid bits travel alongside the data stages
  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Front end: fy, fx, fz
  c2srgb_front #(
    .INPUT_FRAC_BITS(INPUT_FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .en      (adv),
    .l_value (in_l_value),
    .a_value (in_a_value),
    .b_value (in_b_value),
    .f_o     (f_vec)
  );

  // Inverse Lab function, one lane per axis
  c2srgb_labinv u_inv_x (.clk(clk), .en(adv), .t_i(f_vec.c0), .r_o(lin_vec.c0));
  c2srgb_labinv u_inv_y (.clk(clk), .en(adv), .t_i(f_vec.c1), .r_o(lin_vec.c1));
  c2srgb_labinv u_inv_z (.clk(clk), .en(adv), .t_i(f_vec.c2), .r_o(lin_vec.c2));

  // White point and XYZ to linear RGB
  c2srgb_matrix u_matrix (
    .clk   (clk),
    .en    (adv),
    .lab_i (lin_vec),
    .rgb_o (rgb_vec)
  );

  // Gamma encode each channel; the last stage is the output register
  c2srgb_gamma #(.GAMMA_TABLE_ENTRIES(GAMMA_TABLE_ENTRIES)) u_gam_r (
    .clk(clk), .en(adv), .c_i(rgb_vec.c0), .byte_o(out_red_byte)
  );
  c2srgb_gamma #(.GAMMA_TABLE_ENTRIES(GAMMA_TABLE_ENTRIES)) u_gam_g (
    .clk(clk), .en(adv), .c_i(rgb_vec.c1), .byte_o(out_green_byte)
  );
  c2srgb_gamma #(.GAMMA_TABLE_ENTRIES(GAMMA_TABLE_ENTRIES)) u_gam_b (
    .clk(clk), .en(adv), .c_i(rgb_vec.c2), .byte_o(out_blue_byte)
  );

  // An accepted transaction occupies the first stage
  `C2S_ASSERT_NXT(a_enter, rst_n && in_valid && in_ready, vld_r[0])
  // A held pipeline keeps every valid bit
  `C2S_ASSERT_NXT(a_hold, rst_n && !adv, $stable(vld_r))
  // The second-to-last stage feeds the output register when advancing
  `C2S_ASSERT_NXT(a_drain, rst_n && adv && vld_r[LAT-2], out_valid)
  // An empty output register never blocks the input
  `C2S_ASSERT_IMP(a_open, rst_n && !out_valid, in_ready)

endmodule

`default_nettype wire

// ----- sim/tb_cielab_to_srgb_converter_top.sv -----
// ----------------------------------------------------------------------------
// CIELAB to sRGB converter testbench
// Drives Lab colors through the valid/ready port with random gaps on both
// sides, predicts each RGB byte triple in Q3.16 and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cielab_to_srgb_converter_top;

  localparam int FRAC_BITS = 8;
  localparam int GAM_PTS = 1024;
  localparam longint SAT_HI = 524287;
  localparam longint SAT_LO = -524288;

  typedef struct {
    logic [14:0] l_val;
    logic signed [15:0] a_val;
    logic signed [15:0] b_val;
  } lab_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [14:0] in_l_value;
  logic signed [15:0] in_a_value;
  logic signed [15:0] in_b_value;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_red_byte;
  logic [7:0] out_green_byte;
  logic [7:0] out_blue_byte;

  lab_t pending_colors[$];
  rgb_t expected_rgb[$];
  longint gamma_curve[GAM_PTS + 1];
  int error_count;
  int sent_count;
  int checked_count;
  bit stimulus_done;

  cielab_to_srgb_converter_top #(
    .INPUT_FRAC_BITS(FRAC_BITS),
    .GAMMA_TABLE_ENTRIES(GAM_PTS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_l_value(in_l_value),
    .in_a_value(in_a_value),
    .in_b_value(in_b_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red_byte(out_red_byte),
    .out_green_byte(out_green_byte),
    .out_blue_byte(out_blue_byte)
  );

  // 20 ns clock: two half-period delays.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point helpers for the color predictor
  // ---------------------------------------------------------------------------

  // Divide with rounding half away from zero.
  function automatic longint div_away(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clip_q(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Q30 product with rounding; operands stay small enough for 64 bits.
  function automatic longint unsigned q30_mul(longint unsigned x, longint unsigned y);
    return (x * y + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned q30_pow(longint unsigned x, int n);
    longint unsigned r;
    r = 64'd1 << 30;
    for (int k = 0; k < n; k++) r = q30_mul(r, x);
    return r;
  endfunction

  // Build the sRGB curve points 1.055*x^(1/2.4)-0.055 by bisection on x^5.
  task automatic build_gamma_curve();
    longint unsigned x;
    longint unsigned x5;
    longint lo;
    longint hi;
    longint mid;
    for (int i = 0; i <= GAM_PTS; i++) begin
      x = ((longint'(i) << 30) + GAM_PTS / 2) / GAM_PTS;
      x5 = q30_pow(x, 5);
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (q30_pow(longint'(mid) << 14, 12) <= x5) lo = mid;
        else hi = mid - 1;
      end
      gamma_curve[i] = div_away(69140 * lo, 65536) - 3604;
    end
  endtask

  // Inverse Lab function: cube above 6/29, linear segment at or below it.
  function automatic longint lab_finv(longint t);
    longint unsigned u;
    if (t > 13559) begin
      u = t;
      return clip_q(longint'((u * u * u + (64'd1 << 31)) >> 32));
    end
    return clip_q(div_away(8416 * (t - 9039), 65536));
  endfunction

  // Gamma-encode a linear Q16 channel and round to a clamped byte.
  function automatic logic [7:0] encode_channel(longint c);
    longint v;
    longint pos;
    longint idx;
    longint frac;
    longint g;
    if (c <= 205) begin
      v = div_away(c * 32946, 655360);
    end else if (c >= 65536) begin
      v = 255;
    end else begin
      pos = c * GAM_PTS;
      idx = pos / 65536;
      frac = pos % 65536;
      g = gamma_curve[idx] + div_away((gamma_curve[idx + 1] - gamma_curve[idx]) * frac, 65536);
      v = div_away(g * 255, 65536);
    end
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic rgb_t lab_to_rgb(lab_t c);
    longint scale;
    longint fy, fx, fz, xw, yw, zw, rl, gl, bl;
    rgb_t res;
    scale = longint'(1) << (16 - FRAC_BITS);
    fy = clip_q(div_away(longint'(c.l_val) * scale + 16 * 65536, 116));
    fx = clip_q(fy + div_away(longint'(c.a_val) * scale, 500));
    fz = clip_q(fy - div_away(longint'(c.b_val) * scale, 200));
    xw = clip_q(div_away(62290 * lab_finv(fx), 65536));
    yw = lab_finv(fy);
    zw = clip_q(div_away(71358 * lab_finv(fz), 65536));
    rl = clip_q(div_away(212366 * xw - 100738 * yw - 32672 * zw, 65536));
    gl = clip_q(div_away(-63522 * xw + 122946 * yw + 2723 * zw, 65536));
    bl = clip_q(div_away(3647 * xw - 13371 * yw + 69286 * zw, 65536));
    res.red = encode_channel(rl);
    res.green = encode_channel(gl);
    res.blue = encode_channel(bl);
    return res;
  endfunction

  task automatic queue_color(int l, int a, int b);
    lab_t c;
    c.l_val = l[14:0];
    c.a_val = a[15:0];
    c.b_val = b[15:0];
    pending_colors = {pending_colors, c};
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on transaction %0d: %s got %0d expected %0d",
             checked_count, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold valid and payload until accepted, then advance the queue.
  // ---------------------------------------------------------------------------
  int drv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap <= 0;
    end else if (in_valid && !in_ready) begin
      // hold the current transaction
    end else begin
      if (in_valid) begin
        expected_rgb = {expected_rgb,
                        lab_to_rgb(lab_t'{in_l_value, in_a_value, in_b_value})};
        sent_count++;
      end
      if (drv_gap > 0) begin
        in_valid <= 1'b0;
        drv_gap <= drv_gap - 1;
      end else if (pending_colors.size() > 0) begin
        lab_t c;
        c = pending_colors.pop_front();
        in_valid <= 1'b1;
        in_l_value <= c.l_val;
        in_a_value <= c.a_val;
        in_b_value <= c.b_val;
        drv_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction and
  // stall the output side at random.
  // ---------------------------------------------------------------------------
  int mon_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      mon_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rgb.size() == 0) begin
          $display("unexpected result transaction: %0d %0d %0d",
                   out_red_byte, out_green_byte, out_blue_byte);
          error_count++;
        end else begin
          rgb_t e;
          e = expected_rgb.pop_front();
          if (out_red_byte !== e.red) report_mismatch("red", out_red_byte, e.red);
          if (out_green_byte !== e.green) report_mismatch("green", out_green_byte, e.green);
          if (out_blue_byte !== e.blue) report_mismatch("blue", out_blue_byte, e.blue);
        end
        checked_count++;
      end
      if (mon_gap > 0) begin
        out_ready <= 1'b0;
        mon_gap <= mon_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) mon_gap <= pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    stimulus_done = 0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_l_value = '0;
    in_a_value = '0;
    in_b_value = '0;
    rst_n = 1'b0;
    build_gamma_curve();

    // Directed: black, white, axis extremes, knee region, L above 100,
    // negative linear channels and channels above one.
    queue_color(0, 0, 0);
    queue_color(25600, 0, 0);
    queue_color(32767, 0, 0);
    queue_color(32767, 32767, -32768);
    queue_color(0, -32768, 32767);
    queue_color(0, 32767, 32767);
    queue_color(0, -32768, -32768);
    queue_color(25600, 32767, 32767);
    queue_color(25600, -32768, -32768);
    queue_color(2048, 0, 0);
    queue_color(2047, 0, 0);
    queue_color(2049, 0, 0);
    queue_color(256, 0, 0);
    queue_color(12800, 20480, 0);
    queue_color(12800, -20480, 0);
    queue_color(12800, 0, 20480);
    queue_color(12800, 0, -20480);
    queue_color(13000, 21000, 17000);
    queue_color(8000, -30000, 30000);
    queue_color(25600, -1, 1);
    queue_color(30000, -32768, 32767);
    queue_color(1, 1, -1);

    // Random: mostly plausible colors, some fully random bit patterns,
    // some near the dark end where the linear gamma segment applies.
    repeat (1130) begin
      r = $urandom_range(0, 9);
      if (r < 6) queue_color($urandom_range(0, 25600), $urandom_range(0, 64000) - 32000,
                             $urandom_range(0, 64000) - 32000);
      else if (r < 8) queue_color($urandom_range(0, 32767), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535));
      else queue_color($urandom_range(0, 3000), $urandom_range(0, 4000) - 2000,
                       $urandom_range(0, 4000) - 2000);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_colors.size() == 0 && !in_valid);
    wait (expected_rgb.size() == 0);
    repeat (40) @(posedge clk);
    $display("covered %0d Lab transactions, %0d RGB results checked", sent_count,
             checked_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Timeout: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", expected_rgb.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/c2srgb_pkg.sv
hw/rtl/c2srgb_front.sv
hw/rtl/c2srgb_labinv.sv
hw/rtl/c2srgb_matrix.sv
hw/rtl/c2srgb_gamma.sv
hw/rtl/cielab_to_srgb_converter_top.sv
sim/tb_cielab_to_srgb_converter_top.sv
